// File: hw/rtl/bfdh_pkg.sv
// bfdh_pkg: shared types and constants of the double-hash bloom filter.
// Holds the controller/datapath command and status structs and register codes.
// No dependencies.
package bfdh_pkg;

    localparam int HASH_W = 64;
    localparam logic [HASH_W-1:0] DJB_SEED = 64'd5381;
    localparam int FB_W = 14;
    localparam int HC_W = 5;
    localparam int NB_W = FB_W + 3;
    localparam int DCNT_W = 6;
    localparam int BYTE_W = 8;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;
    localparam logic [FB_W-1:0] FB_RESET = 14'd8192;
    localparam logic [HC_W-1:0] HC_RESET = 5'd3;

    typedef enum logic {
        REG_FILTER_BYTES = 1'b0,
        REG_HASH_COUNT   = 1'b1
    } t_reg;

    typedef struct packed {
        logic hash_en;
        logic clr_we;
        logic load;
        logic div_start;
        logic div_step;
        logic rd_en;
        logic eval;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic k_zero;
        logic div_last;
        logic stop;
        logic probe_last;
    } t_sts;

endpackage

// File: hw/rtl/bfdh_in_if.sv
// bfdh_in_if: key byte channel, valid/ready handshake.
// Depends on nothing.
interface bfdh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_byte;
    logic       last_byte;
    logic       opcode;

    modport source (output valid, output key_byte, output last_byte, output opcode,
                    input ready);
    modport sink (input valid, input key_byte, input last_byte, input opcode,
                  output ready);
endinterface

// File: hw/rtl/bfdh_out_if.sv
// bfdh_out_if: result channel, valid/ready handshake.
// Depends on nothing.
interface bfdh_out_if;
    logic valid;
    logic ready;
    logic was_search;
    logic found;

    modport source (output valid, output was_search, output found, input ready);
    modport sink (input valid, input was_search, input found, output ready);
endinterface

// File: hw/rtl/bfdh_ram.sv
// bfdh_ram: generic one-write, one-read RAM with registered read data.
// No dependencies.
module bfdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/bfdh_datapath.sv
// bfdh_datapath: running hashes, probe generator, serial modulo unit, bit store.
// Depends on bfdh_pkg and bfdh_ram.
module bfdh_datapath #(
    parameter int MAX_FILTER_BYTES = 8192,
    parameter int MAX_HASHES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bfdh_pkg::t_cmd                i_cmd,
    output bfdh_pkg::t_sts                o_sts,
    input  logic [bfdh_pkg::BYTE_W-1:0]   i_key_byte,
    input  logic                          i_last_byte,
    input  logic                          i_opcode,
    input  logic [bfdh_pkg::FB_W-1:0]     i_filter_bytes,
    input  logic [bfdh_pkg::HC_W-1:0]     i_hash_count,
    output logic                          o_was_search,
    output logic                          o_found
);
    localparam int AW = (MAX_FILTER_BYTES > 1) ? $clog2(MAX_FILTER_BYTES) : 1;
    localparam int IW = $clog2(MAX_HASHES + 1);
    localparam int HW = bfdh_pkg::HASH_W;
    localparam int NW = bfdh_pkg::NB_W;

    logic [HW-1:0] r_djb, r_sdbm, r_h, r_sd, r_dvd;
    logic [HW-1:0] n_djb, n_sdbm, kb_ext;
    logic [NW-1:0] r_rem, r_nb, n_rem, n_nb;
    logic [NW:0]   rem_pre;
    logic [bfdh_pkg::DCNT_W-1:0] r_dcnt;
    logic [IW-1:0] r_i, r_k, n_k;
    logic [AW-1:0] r_clr, addr, waddr;
    logic [2:0]    bit_sel;
    logic [7:0]    rdata, wdata;
    logic          r_search, r_found, r_out_search, r_out_found;
    logic          ram_we, miss;
    int            fb_eff, hc_eff;

    assign kb_ext = HW'(i_key_byte);
    assign n_djb  = (r_djb << 5) + r_djb + kb_ext;
    assign n_sdbm = kb_ext + (r_sdbm << 6) + (r_sdbm << 16) - r_sdbm;

    always_comb begin
        fb_eff = int'(i_filter_bytes);
        if (fb_eff == 0) begin
            fb_eff = 1;
        end
        if (fb_eff > MAX_FILTER_BYTES) begin
            fb_eff = MAX_FILTER_BYTES;
        end
        hc_eff = int'(i_hash_count);
        if (hc_eff > MAX_HASHES) begin
            hc_eff = MAX_HASHES;
        end
    end

    assign n_nb = {bfdh_pkg::FB_W'(fb_eff), 3'b000};
    assign n_k  = IW'(hc_eff);

    assign rem_pre = {r_rem, r_dvd[HW-1]};
    assign n_rem   = (rem_pre >= {1'b0, r_nb}) ? NW'(rem_pre - {1'b0, r_nb}) : rem_pre[NW-1:0];

    assign addr    = AW'(r_rem[NW-1:3]);
    assign bit_sel = r_rem[2:0];
    assign miss    = !rdata[bit_sel];
    assign ram_we  = i_cmd.clr_we || (i_cmd.eval && !r_search);
    assign waddr   = i_cmd.clr_we ? r_clr : addr;
    assign wdata   = i_cmd.clr_we ? 8'h00 : (rdata | (8'h01 << bit_sel));

    bfdh_ram #(
        .WIDTH(8),
        .DEPTH(MAX_FILTER_BYTES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(addr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_djb  <= bfdh_pkg::DJB_SEED;
            r_sdbm <= '0;
            r_clr  <= '0;
            r_dcnt <= '0;
            r_i    <= '0;
            r_k    <= '0;
        end else begin
            if (i_cmd.hash_en) begin
                r_djb  <= n_djb;
                r_sdbm <= n_sdbm;
            end
            if (i_cmd.load) begin
                r_djb  <= bfdh_pkg::DJB_SEED;
                r_sdbm <= '0;
                r_i    <= '0;
                r_k    <= n_k;
            end
            if (i_cmd.clr_we) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.div_start) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + 1'b1;
            end
            if (i_cmd.eval) begin
                r_i <= r_i + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hash_en && i_last_byte) begin
            r_search <= i_opcode;
        end
        if (i_cmd.load) begin
            r_h     <= r_djb;
            r_sd    <= r_sdbm;
            r_nb    <= n_nb;
            r_found <= 1'b1;
        end
        if (i_cmd.div_start) begin
            r_dvd <= r_h;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
        if (i_cmd.eval) begin
            r_h <= r_h + r_sd + HW'({r_i, 1'b1});
            if (r_search && miss) begin
                r_found <= 1'b0;
            end
        end
        if (i_cmd.out_load) begin
            r_out_search <= r_search;
            r_out_found  <= r_search && r_found;
        end
    end

    assign o_sts.clr_done   = (r_clr == AW'(MAX_FILTER_BYTES - 1));
    assign o_sts.k_zero     = (i_hash_count == '0);
    assign o_sts.div_last   = (r_dcnt == '1);
    assign o_sts.stop       = r_search && miss;
    assign o_sts.probe_last = (IW'(r_i + 1'b1) == r_k);

    assign o_was_search = r_out_search;
    assign o_found      = r_out_found;

    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> r_rem < r_nb) else $error("modulo result out of range");
    a_search_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval && r_search |-> !ram_we) else $error("search wrote the bit store");
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval |-> r_i < r_k) else $error("probe index past probe count");
endmodule

// File: hw/rtl/bfdh_ctrl.sv
// bfdh_ctrl: sequencer for clearing, byte intake, probe loop and result transfer.
// Depends on bfdh_pkg.
module bfdh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bfdh_pkg::t_sts i_sts,
    input  logic           i_in_valid,
    input  logic           i_last_byte,
    input  logic           i_out_ready,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output bfdh_pkg::t_cmd o_cmd
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_PREP, S_START, S_DIV, S_ADDR, S_EVAL, S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.hash_en   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.clr_we    = (r_state == S_CLEAR);
        o_cmd.load      = (r_state == S_PREP);
        o_cmd.div_start = (r_state == S_START);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.rd_en     = (r_state == S_ADDR);
        o_cmd.eval      = (r_state == S_EVAL);
        o_cmd.out_load  = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid && i_last_byte) n_state = S_PREP;
            end
            S_PREP: begin
                n_state = i_sts.k_zero ? S_FINISH : S_START;
            end
            S_START: n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_last) n_state = S_ADDR;
            end
            S_ADDR: n_state = S_EVAL;
            S_EVAL: begin
                n_state = (i_sts.stop || i_sts.probe_last) ? S_FINISH : S_START;
            end
            S_FINISH: begin
                if (o_cmd.out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_last_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && i_in_valid && i_last_byte |=> r_state == S_PREP)
        else $error("last byte did not start the probe loop");
    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !r_out_valid || i_out_ready)
        else $error("result overwritten before transfer");
    a_clear_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_in_ready && !r_out_valid)
        else $error("activity during clearing pass");
endmodule

// File: hw/rtl/bloom_filter_double_hash.sv
// bloom_filter_double_hash: top level of the double-hash bloom filter.
// Depends on bfdh_pkg, bfdh_in_if, bfdh_out_if, bfdh_ctrl, bfdh_datapath, bfdh_ram.
//
// Key bytes enter on i_key (valid/ready), one transfer per cycle while idle.
// Each byte updates the djb2 and sdbm hashes; the byte marked last_byte ends
// the key, and its opcode picks insert (0) or search (1).
// After the last byte the block runs hash_count probes, at most MAX_HASHES. Each
// probe runs a bit-serial modulo unit, then a read of the byte-wide bit store
// and, for an insert, a write. A search stops at its first clear bit, and the
// next key byte is taken once the result is registered.
// Results leave on o_res (valid/ready) from an output register; the block
// accepts the next key while a result waits, and holds before loading a
// second result until the first one transfers.
// After reset the bit store is cleared one byte per cycle, all MAX_FILTER_BYTES
// bytes, with i_key.ready low; APB writes are taken during that time.
// Registers: filter_bytes at 0x0, hash_count at 0x4.
module bloom_filter_double_hash #(
    parameter int MAX_FILTER_BYTES = 8192,
    parameter int MAX_HASHES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bfdh_in_if.sink                       i_key,
    bfdh_out_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfdh_pkg::ADDR_W-1:0]   paddr,
    input  logic [bfdh_pkg::DATA_W-1:0]   pwdata,
    output logic [bfdh_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    logic [bfdh_pkg::FB_W-1:0] r_filter_bytes;
    logic [bfdh_pkg::HC_W-1:0] r_hash_count;
    bfdh_pkg::t_cmd cmd;
    bfdh_pkg::t_sts sts;
    bfdh_pkg::t_reg reg_sel;

    assign reg_sel = bfdh_pkg::t_reg'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_bytes <= bfdh_pkg::FB_RESET;
            r_hash_count   <= bfdh_pkg::HC_RESET;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                bfdh_pkg::REG_FILTER_BYTES: r_filter_bytes <= pwdata[bfdh_pkg::FB_W-1:0];
                bfdh_pkg::REG_HASH_COUNT:   r_hash_count   <= pwdata[bfdh_pkg::HC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            bfdh_pkg::REG_FILTER_BYTES: prdata = bfdh_pkg::DATA_W'(r_filter_bytes);
            bfdh_pkg::REG_HASH_COUNT:   prdata = bfdh_pkg::DATA_W'(r_hash_count);
            default:                    prdata = '0;
        endcase
    end

    bfdh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (sts),
        .i_in_valid (i_key.valid),
        .i_last_byte(i_key.last_byte),
        .i_out_ready(o_res.ready),
        .o_in_ready (i_key.ready),
        .o_out_valid(o_res.valid),
        .o_cmd      (cmd)
    );

    bfdh_datapath #(
        .MAX_FILTER_BYTES(MAX_FILTER_BYTES),
        .MAX_HASHES      (MAX_HASHES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_key_byte    (i_key.key_byte),
        .i_last_byte   (i_key.last_byte),
        .i_opcode      (i_key.opcode),
        .i_filter_bytes(r_filter_bytes),
        .i_hash_count  (r_hash_count),
        .o_was_search  (o_res.was_search),
        .o_found       (o_res.found)
    );
endmodule

// File: sim/bfdh_test_pkg.sv
`timescale 1ns / 100ps
// bfdh_test_pkg: key transfer and verdict types for the testbench.
// No dependencies.
package bfdh_test_pkg;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       last_byte;
        logic       opcode;
    } t_key_xfer;

    typedef struct packed {
        logic was_search;
        logic found;
    } t_verdict;

    localparam int FILTER_BITS = 65536;

endpackage

// File: sim/bloom_filter_double_hash_test.sv
`timescale 1ns / 100ps
// bloom_filter_double_hash_test: self-checking testbench of the double-hash bloom filter.
// Depends on bfdh_pkg, bfdh_test_pkg, bfdh_in_if, bfdh_out_if and the block itself.
module bloom_filter_double_hash_test;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [bfdh_pkg::ADDR_W-1:0] paddr = '0;
    logic [bfdh_pkg::DATA_W-1:0] pwdata = '0;
    logic [bfdh_pkg::DATA_W-1:0] prdata;
    logic pready;

    bfdh_in_if  key_ch ();
    bfdh_out_if res_ch ();

    bloom_filter_double_hash DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key(key_ch.sink), .o_res(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic                          filter_map [bfdh_test_pkg::FILTER_BITS];
    logic [63:0]                   djb_hash = bfdh_pkg::DJB_SEED;
    logic [63:0]                   sdbm_hash = '0;
    logic [bfdh_pkg::FB_W-1:0]     size_reg = bfdh_pkg::FB_RESET;
    logic [bfdh_pkg::HC_W-1:0]     probe_reg = bfdh_pkg::HC_RESET;

    bfdh_test_pkg::t_key_xfer pending_bytes [$];
    bfdh_test_pkg::t_verdict  expected_verdicts [$];
    int        mismatch_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        recv_hold_cycles = 0;
    bit        send_hold = 1'b0;

    function automatic void absorb_byte(bfdh_test_pkg::t_key_xfer x);
        logic [63:0] nbits, h, pos;
        int k;
        bit all_set;
        bfdh_test_pkg::t_verdict v;
        djb_hash  = (djb_hash << 5) + djb_hash + 64'(x.key_byte);
        sdbm_hash = 64'(x.key_byte) + (sdbm_hash << 6) + (sdbm_hash << 16) - sdbm_hash;
        if (!x.last_byte) return;
        nbits = (size_reg == 0) ? 64'd8
              : (size_reg > 8192) ? 64'd65536 : 64'(size_reg) * 8;
        k = (probe_reg > 16) ? 16 : int'(probe_reg);
        all_set = 1'b1;
        for (int i = 0; i < k; i++) begin
            h = djb_hash + 64'(i) * sdbm_hash + 64'(i * i);
            pos = h % nbits;
            if (x.opcode == OP_SEARCH) begin
                if (!filter_map[pos]) begin
                    all_set = 1'b0;
                    break;
                end
            end else begin
                filter_map[pos] = 1'b1;
            end
        end
        djb_hash = bfdh_pkg::DJB_SEED;
        sdbm_hash = '0;
        v.was_search = x.opcode;
        v.found = (x.opcode == OP_SEARCH) && all_set;
        expected_verdicts.push_back(v);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_ch.valid <= 1'b0;
            key_ch.key_byte <= 8'd1;
            key_ch.last_byte <= 1'b0;
            key_ch.opcode <= OP_INSERT;
        end else begin
            if (key_ch.valid && key_ch.ready) begin
                absorb_byte({key_ch.key_byte, key_ch.last_byte, key_ch.opcode});
                void'(pending_bytes.pop_front());
            end
            if ((!key_ch.valid || key_ch.ready)) begin
                if (pending_bytes.size() > (key_ch.valid && key_ch.ready ? 0 : 0) &&
                    !send_hold && $urandom_range(99) >= send_idle_pct) begin
                    key_ch.valid <= 1'b1;
                    {key_ch.key_byte, key_ch.last_byte, key_ch.opcode} <= pending_bytes[0];
                end else begin
                    key_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver hold counter
    always @(posedge i_clk) begin
        if (recv_hold_cycles != 0) begin
            recv_hold_cycles <= recv_hold_cycles - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        bfdh_test_pkg::t_verdict exp_v;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_verdicts.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: was_search=%0b found=%0b",
                                 res_ch.was_search, res_ch.found);
                end else begin
                    exp_v = expected_verdicts.pop_front();
                    if (exp_v.was_search !== res_ch.was_search ||
                        exp_v.found !== res_ch.found) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected ws=%0b f=%0b, got ws=%0b f=%0b",
                                     exp_v.was_search, exp_v.found,
                                     res_ch.was_search, res_ch.found);
                    end
                end
            end
            res_ch.ready <= (recv_hold_cycles == 0) &&
                            ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic apb_write(bfdh_pkg::t_reg idx, logic [bfdh_pkg::DATA_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= bfdh_pkg::ADDR_W'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == bfdh_pkg::REG_FILTER_BYTES) size_reg = val[bfdh_pkg::FB_W-1:0];
        else probe_reg = val[bfdh_pkg::HC_W-1:0];
    endtask

    task automatic drain_all();
        while (pending_bytes.size() != 0 || key_ch.valid || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (2 + 67 * 16 + 10) @(posedge i_clk);
    endtask

    task automatic queue_key(int len, logic op, bit small_alpha);
        bfdh_test_pkg::t_key_xfer x;
        for (int b = 0; b < len; b++) begin
            x.key_byte = small_alpha ? 8'($urandom_range(1, 4)) : 8'($urandom_range(1, 255));
            x.last_byte = (b == len - 1);
            x.opcode = (b == len - 1) ? op : logic'($urandom_range(1));
            pending_bytes.push_back(x);
        end
    endtask

    task automatic queue_fixed(logic [7:0] kb, logic op);
        pending_bytes.push_back('{kb, 1'b1, op});
    endtask

    task automatic random_phase(int n_keys, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int j = 0; j < n_keys; j++)
            queue_key($urandom_range(1, 4), logic'($urandom_range(1)), 1'(j % 2));
        drain_all();
    endtask

    initial begin
        for (int i = 0; i < bfdh_test_pkg::FILTER_BITS; i++) filter_map[i] = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, insert then search, zero bytes, long key
        queue_fixed(8'hFF, OP_INSERT);
        queue_fixed(8'hFF, OP_SEARCH);
        queue_fixed(8'h00, OP_SEARCH);
        queue_fixed(8'h00, OP_INSERT);
        queue_fixed(8'h00, OP_SEARCH);
        pending_bytes.push_back('{8'h01, 1'b0, OP_SEARCH});
        pending_bytes.push_back('{8'h80, 1'b0, OP_INSERT});
        queue_fixed(8'h7F, OP_INSERT);
        pending_bytes.push_back('{8'h01, 1'b0, OP_INSERT});
        pending_bytes.push_back('{8'h80, 1'b0, OP_INSERT});
        queue_fixed(8'h7F, OP_SEARCH);
        queue_fixed(8'h55, OP_SEARCH);
        drain_all();
        apb_write(bfdh_pkg::REG_HASH_COUNT, 32'd0);
        queue_fixed(8'hAA, OP_INSERT);
        queue_fixed(8'hAA, OP_SEARCH);
        drain_all();
        apb_write(bfdh_pkg::REG_HASH_COUNT, 32'd31);
        apb_write(bfdh_pkg::REG_FILTER_BYTES, 32'd0);
        queue_fixed(8'h12, OP_INSERT);
        queue_fixed(8'h34, OP_SEARCH);
        drain_all();
        apb_write(bfdh_pkg::REG_FILTER_BYTES, 32'h3FFF);
        apb_write(bfdh_pkg::REG_HASH_COUNT, 32'd16);
        queue_fixed(8'h12, OP_SEARCH);
        drain_all();
        apb_write(bfdh_pkg::REG_FILTER_BYTES, 32'd1);
        apb_write(bfdh_pkg::REG_HASH_COUNT, 32'd2);
        random_phase(35, 0, 0);
        // pressure: long receiver hold while bytes keep coming
        recv_hold_cycles = 600;
        for (int j = 0; j < 6; j++) queue_key(2, OP_INSERT, 1'b0);
        wait (recv_hold_cycles == 0);
        drain_all();
        apb_write(bfdh_pkg::REG_FILTER_BYTES, 32'd3);
        apb_write(bfdh_pkg::REG_HASH_COUNT, 32'd1);
        random_phase(40, 60, 0);
        apb_write(bfdh_pkg::REG_FILTER_BYTES, 32'd8192);
        apb_write(bfdh_pkg::REG_HASH_COUNT, 32'd3);
        random_phase(40, 0, 60);
        apb_write(bfdh_pkg::REG_FILTER_BYTES, 32'd16);
        apb_write(bfdh_pkg::REG_HASH_COUNT, 32'd5);
        random_phase(40, 30, 30);
        apb_write(bfdh_pkg::REG_FILTER_BYTES, 32'd2);
        apb_write(bfdh_pkg::REG_HASH_COUNT, 32'd4);
        random_phase(40, 0, 0);
        // sender holds until all results are back, then resumes
        send_hold = 1'b1;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        send_hold = 1'b0;
        apb_write(bfdh_pkg::REG_FILTER_BYTES, 32'd64);
        apb_write(bfdh_pkg::REG_HASH_COUNT, 32'd1);
        random_phase(40, 30, 30);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
